// ===== rtl/swhs_pkg.sv =====
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
`default_nettype none

package swhs_pkg;

  // Line sequencer phase codes.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START     = 3'd1;
  localparam logic [2:0] PH_RELEASE   = 3'd2;
  localparam logic [2:0] PH_PRE_LOW   = 3'd3;
  localparam logic [2:0] PH_PRE_HIGH  = 3'd4;
  localparam logic [2:0] PH_DATA_LOW  = 3'd5;
  localparam logic [2:0] PH_DATA_HIGH = 3'd6;

  // Completion status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // Request kinds carried on the input tuser.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_LOW = 2'd0;
  localparam logic [1:0] REG_RELEASE   = 2'd1;
  localparam logic [1:0] REG_ONE_THR   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  // Register reset values.
  localparam logic [15:0] START_LOW_RST = 16'd20000;
  localparam logic [7:0]  RELEASE_RST   = 8'd40;
  localparam logic [9:0]  ONE_THR_RST   = 10'd50;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;

  // Number of data bits in one reading.
  localparam logic [5:0] TOTAL_BITS = 6'd40;

  // Widths of the stream words.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [15:0] start_low;
    logic [7:0]  release_len;
    logic [9:0]  one_thr;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/swhs_cfg.sv =====
// ----------------------------------------------------------------------------
// swhs_cfg
// Configuration register file: start pulse, release, bit threshold, timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module swhs_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_addr,
  input  wire logic [15:0]   wr_data,
  output swhs_pkg::cfg_t     cfg
);
  import swhs_pkg::*;

  cfg_t cfg_r;

  // Each write request updates one register, truncated to its width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low   <= START_LOW_RST;
      cfg_r.release_len <= RELEASE_RST;
      cfg_r.one_thr     <= ONE_THR_RST;
      cfg_r.timeout     <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (wr_addr)
        REG_START_LOW: cfg_r.start_low   <= wr_data;
        REG_RELEASE:   cfg_r.release_len <= wr_data[7:0];
        REG_ONE_THR:   cfg_r.one_thr     <= wr_data[9:0];
        REG_TIMEOUT:   cfg_r.timeout     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/swhs_core.sv =====
// ----------------------------------------------------------------------------
// swhs_core
// Line sequencer: one tick or start request per step, with decode and
// checksum of the 40 received bits.
// ----------------------------------------------------------------------------
`default_nettype none

module swhs_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic          func,
  input  wire logic          line_level,
  input  wire swhs_pkg::cfg_t cfg,
  output swhs_pkg::result_t  res
);
  import swhs_pkg::*;

  logic [2:0]         phase_r, phase_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic [5:0]         bitcnt_r, bitcnt_nxt;
  logic [39:0]        bits_r, bits_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  logic [15:0]        hum_r, hum_nxt;

  logic [15:0] cnt_inc;
  logic        expected;
  logic        bit_val;
  logic [39:0] bits_sh;
  logic [7:0]  sum8;
  logic        chk_ok;
  logic [15:0] mag;
  logic [15:0] temp_dec;
  logic        done;
  logic [1:0]  status;
  logic        ended;

  // Decode of the word that would result from shifting in the current bit.
  assign cnt_inc  = cnt_r + 16'd1;
  assign expected = (phase_r == PH_PRE_HIGH) || (phase_r == PH_DATA_HIGH);
  assign bit_val  = (cnt_r > {6'd0, cfg.one_thr});
  assign bits_sh  = {bits_r[38:0], bit_val};
  assign sum8     = bits_sh[39:32] + bits_sh[31:24] + bits_sh[23:16] + bits_sh[15:8];
  assign chk_ok   = (sum8 == bits_sh[7:0]);
  assign mag      = {1'b0, bits_sh[22:16], bits_sh[15:8]};
  assign temp_dec = bits_sh[23] ? (16'd0 - mag) : mag;

  // Next state for one step.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    bitcnt_nxt = bitcnt_r;
    bits_nxt   = bits_r;
    temp_nxt   = temp_r;
    hum_nxt    = hum_r;
    done       = 1'b0;
    status     = ST_OK;
    ended      = 1'b0;
    if (step_en) begin
      if (func == FUNC_START) begin
        phase_nxt  = PH_START;
        cnt_nxt    = 16'd1;
        bitcnt_nxt = 6'd0;
        bits_nxt   = 40'd0;
        if (16'd1 >= cfg.start_low) begin
          phase_nxt = PH_RELEASE;
          cnt_nxt   = 16'd0;
        end
      end else begin
        case (phase_r)
          PH_START: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= cfg.start_low) begin
              phase_nxt = PH_RELEASE;
              cnt_nxt   = 16'd0;
            end
          end
          PH_RELEASE: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= {8'd0, cfg.release_len}) begin
              phase_nxt = PH_PRE_LOW;
              cnt_nxt   = 16'd0;
            end
          end
          PH_PRE_LOW, PH_PRE_HIGH, PH_DATA_LOW, PH_DATA_HIGH: begin
            if (line_level == expected) begin
              cnt_nxt = cnt_inc;
            end else begin
              // A level change closes the phase; a closed high data phase is a bit.
              if (phase_r == PH_DATA_HIGH) begin
                bits_nxt   = bits_sh;
                bitcnt_nxt = bitcnt_r + 6'd1;
                if (bitcnt_nxt >= TOTAL_BITS) begin
                  ended     = 1'b1;
                  done      = 1'b1;
                  phase_nxt = PH_IDLE;
                  cnt_nxt   = 16'd0;
                  if (chk_ok) begin
                    hum_nxt  = bits_sh[39:24];
                    temp_nxt = temp_dec;
                  end else begin
                    status = ST_CHECKSUM;
                  end
                end
              end
              if (!ended) begin
                phase_nxt = (phase_r == PH_DATA_HIGH) ? PH_DATA_LOW : phase_r + 3'd1;
                cnt_nxt   = 16'd1;
              end
            end
            if (!ended && (cnt_nxt >= cfg.timeout)) begin
              done      = 1'b1;
              status    = ST_TIMEOUT;
              phase_nxt = PH_IDLE;
              cnt_nxt   = 16'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= 16'd0;
      bitcnt_r <= 6'd0;
      bits_r   <= 40'd0;
      temp_r   <= 16'sd0;
      hum_r    <= 16'd0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      bitcnt_r <= bitcnt_nxt;
      bits_r   <= bits_nxt;
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
    end
  end

  // Result reflects the state after the step.
  always_comb begin
    res.drive_low   = (phase_nxt == PH_START);
    res.busy        = (phase_nxt != PH_IDLE);
    res.done        = done;
    res.status      = done ? status : ST_OK;
    res.temperature = temp_nxt;
    res.humidity    = hum_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Tick-driven reader for a single-wire temperature and humidity sensor.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per tick: tuser selects a plain tick
//   with the sampled line level in tdata bit 0, or a request to start a new
//   reading. Every request produces exactly one result on the output stream:
//   the line drive, busy, done and status flags and the last good humidity
//   and temperature in tenths.
//   The configuration channel writes the start pulse length, release time,
//   one-bit threshold and phase timeout; write only while the block is idle.
// Timing:
//   A request accepted at one clock edge is captured in the input register and
//   its result is loaded into the output register once the output is not
//   stalled. One request per clock cycle is taken sustained while the output
//   is not stalled; the sequencer step between the registers sets that rate.
// Reset and stall:
//   Reset returns the sequencer to idle, clears the held readings and restores
//   the default configuration. When the output is stalled the result holds and
//   the input register takes one more request before in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_humidity_sensor_reader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output wire logic        in_tready,
  // [0] line_level, [7:1] zero
  input  wire logic [swhs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic        in_tuser,   // [0] func
  // Result stream.
  output wire logic        out_tvalid,
  input  wire logic        out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
  // [20:5] temperature_tenths, [36:21] humidity_tenths, [39:37] zero
  output wire logic [swhs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);
  import swhs_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic                   stg_valid_r;
  logic                   stg_func_r;
  logic                   stg_level_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   advance;
  logic                   in_accept;

  assign advance   = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = !stg_valid_r || advance;
  assign cfg_ready = 1'b1;

  swhs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  swhs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (stg_valid_r && advance),
    .func       (stg_func_r),
    .line_level (stg_level_r),
    .cfg        (cfg),
    .res        (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_accept) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_func_r  <= in_tuser;
      stg_level_r <= in_tdata[0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid_r && advance) begin
      out_data_r <= {3'd0, res.humidity, res.temperature, res.status,
                     res.done, res.busy, res.drive_low};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/swhs_checker.sv =====
// ----------------------------------------------------------------------------
// swhs_checker
// Port-level checks on the result stream of the sensor reader.
// ----------------------------------------------------------------------------
`default_nettype none

module swhs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  import swhs_pkg::*;

  // A stalled result keeps its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A nonzero status only comes with done.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[4:3] == ST_OK)
    else $error("status set without done");

  // Status is one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:3] == ST_OK || out_tdata[4:3] == ST_TIMEOUT ||
                   out_tdata[4:3] == ST_CHECKSUM)
    else $error("undefined status code");

  // Pulling the line low only happens during a reading.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("line driven while not busy");

  // A finished reading leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("busy on the finishing result");

endmodule

bind single_wire_humidity_sensor_reader swhs_checker u_swhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== sim/single_wire_humidity_sensor_reader_test.sv =====
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_test
// Self-checking bench for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
// Requests on the input stream are the line ticks and start requests of a
// simulated sensor. A behavioral copy of the line sequencer runs on every
// accepted request and queues the readout it should produce. Each readout on
// the result stream is checked field by field against the oldest entry. The
// bench runs directed readings (good, signed, negative zero, bad checksum,
// timeouts in every phase, restart while busy) and then random readings under
// several register settings, including the extremes, with random back-pressure
// on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_test;
  import swhs_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_TICKS  = 450;
  localparam int MAX_REPORTS   = 10;
  localparam int LATENCY_SLACK = 6;
  localparam int DATA_PHASES   = 82;

  typedef struct packed {
    logic func;
    logic level;
  } tick_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata   = '0;    // [0] line_level, [7:1] zero
  logic        in_tuser   = FUNC_TICK;  // [0] func
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
  // [20:5] temperature_tenths, [36:21] humidity_tenths, [39:37] zero
  wire  [39:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_addr   = REG_START_LOW;
  logic [15:0] cfg_data   = '0;

  // Stimulus and scoreboard state.
  tick_t       pending_ticks[$];
  result_t     expected_readouts[$];
  int unsigned ticks_queued  = 0;
  int unsigned ticks_taken   = 0;
  int unsigned readouts_seen = 0;
  int unsigned failures      = 0;
  int unsigned regs_written  = 0;
  int unsigned reads_good    = 0;
  int unsigned reads_timeout = 0;
  int unsigned reads_badsum  = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 80;
  logic        took_tick     = 1'b0;

  // Shadow of the line sequencer and its registers.
  cfg_t        line_cfg  = '{start_low: START_LOW_RST, release_len: RELEASE_RST,
                             one_thr: ONE_THR_RST, timeout: TIMEOUT_RST};
  logic [2:0]  rd_phase  = PH_IDLE;
  logic [15:0] rd_count  = '0;
  logic [5:0]  rd_nbits  = '0;
  logic [39:0] rd_shift  = '0;
  logic [15:0] last_temp = '0;
  logic [15:0] last_hum  = '0;

  single_wire_humidity_sensor_reader u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // Free-running clock.
  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Advances the shadow sequencer by one request and queues its readout.
  task automatic predict_readout(input logic func, input logic level);
    logic        finished;
    logic        ended;
    logic        want_level;
    logic [1:0]  code;
    logic [7:0]  b0, b1, b2, b3, b4, sum;
    logic [15:0] mag;
    result_t     r;
    finished = 1'b0;
    ended    = 1'b0;
    code     = ST_OK;
    if (func == FUNC_START) begin
      rd_phase = PH_START;
      rd_count = 16'd1;
      rd_nbits = '0;
      rd_shift = '0;
      if (rd_count >= line_cfg.start_low) begin
        rd_phase = PH_RELEASE;
        rd_count = '0;
      end
    end else if (rd_phase == PH_START) begin
      rd_count = rd_count + 16'd1;
      if (rd_count >= line_cfg.start_low) begin
        rd_phase = PH_RELEASE;
        rd_count = '0;
      end
    end else if (rd_phase == PH_RELEASE) begin
      rd_count = rd_count + 16'd1;
      if (rd_count >= {8'd0, line_cfg.release_len}) begin
        rd_phase = PH_PRE_LOW;
        rd_count = '0;
      end
    end else if (rd_phase >= PH_PRE_LOW && rd_phase <= PH_DATA_HIGH) begin
      want_level = (rd_phase == PH_PRE_HIGH || rd_phase == PH_DATA_HIGH);
      if (level == want_level) begin
        rd_count = rd_count + 16'd1;
      end else begin
        // A high data phase that ends shifts in one bit.
        if (rd_phase == PH_DATA_HIGH) begin
          rd_shift = {rd_shift[38:0], (rd_count > {6'd0, line_cfg.one_thr})};
          rd_nbits = rd_nbits + 6'd1;
          if (rd_nbits >= TOTAL_BITS) begin
            {b0, b1, b2, b3, b4} = rd_shift;
            sum = b0 + b1 + b2 + b3;
            if (b4 != sum) begin
              code = ST_CHECKSUM;
            end else begin
              last_hum = {b0, b1};
              mag = {1'b0, b2[6:0], b3};
              if (b2[7]) begin
                mag = -mag;
              end
              last_temp = mag;
            end
            finished = 1'b1;
            ended    = 1'b1;
            rd_phase = PH_IDLE;
            rd_count = '0;
          end
        end
        if (!ended) begin
          rd_phase = (rd_phase == PH_DATA_HIGH) ? PH_DATA_LOW : rd_phase + 3'd1;
          rd_count = 16'd1;
        end
      end
      if (!ended && rd_count >= line_cfg.timeout) begin
        finished = 1'b1;
        code     = ST_TIMEOUT;
        rd_phase = PH_IDLE;
        rd_count = '0;
      end
    end
    if (finished) begin
      case (code)
        ST_OK:      reads_good++;
        ST_TIMEOUT: reads_timeout++;
        default:    reads_badsum++;
      endcase
    end
    r.drive_low   = (rd_phase == PH_START);
    r.busy        = (rd_phase != PH_IDLE);
    r.done        = finished;
    r.status      = finished ? code : ST_OK;
    r.temperature = last_temp;
    r.humidity    = last_hum;
    expected_readouts.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("Mismatch in %s of readout %0d: expected %h, got %h",
                 name, readouts_seen, want, got);
      end
    end
  endtask

  task automatic check_readout(input logic [39:0] word);
    result_t want;
    readouts_seen++;
    if (expected_readouts.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("Readout %0d (%h) arrived with nothing outstanding",
                 readouts_seen, word);
      end
      return;
    end
    want = expected_readouts.pop_front();
    compare_field("drive_low", want.drive_low, word[0]);
    compare_field("busy", want.busy, word[1]);
    compare_field("done", want.done, word[2]);
    compare_field("status", want.status, word[4:3]);
    compare_field("temperature", want.temperature, word[20:5]);
    compare_field("humidity", want.humidity, word[36:21]);
    compare_field("padding", 16'd0, {13'd0, word[39:37]});
  endtask

  // Monitor: takes accepted requests into the shadow model, checks readouts.
  always @(posedge clk) begin
    took_tick = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_readout(in_tuser, in_tdata[0]);
        took_tick = 1'b1;
        ticks_taken++;
      end
      if (out_tvalid && out_tready) begin
        check_readout(out_tdata);
      end
    end
  end

  // Driver: presents the next pending request and randomizes the result stall.
  always @(negedge clk) begin : driver
    tick_t next_tick;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || took_tick) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_tick = pending_ticks.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_tick.func;
        in_tdata  <= {7'd0, next_tick.level};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_tick(input logic func, input logic level);
    pending_ticks.push_back('{func: func, level: level});
    ticks_queued++;
  endtask

  task automatic queue_level(input logic level, input int unsigned count);
    repeat (count) queue_tick(FUNC_TICK, level);
  endtask

  // Ticks whose line level the sequencer ignores or that are pure noise.
  task automatic queue_noise(input int unsigned count);
    repeat (count) queue_tick(FUNC_TICK, $urandom_range(1));
  endtask

  // Waits until every request is taken and every readout has been checked.
  task automatic wait_drained();
    while (ticks_taken != ticks_queued || expected_readouts.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_START_LOW: line_cfg.start_low   = value;
      REG_RELEASE:   line_cfg.release_len = value[7:0];
      REG_ONE_THR:   line_cfg.one_thr     = value[9:0];
      default:       line_cfg.timeout     = value;
    endcase
    regs_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_timing(input logic [15:0] start_low, input logic [7:0] rel,
                              input logic [9:0] thr, input logic [15:0] tmo);
    wait_drained();
    write_register(REG_START_LOW, start_low);
    write_register(REG_RELEASE, {8'd0, rel});
    write_register(REG_ONE_THR, {6'd0, thr});
    write_register(REG_TIMEOUT, tmo);
  endtask

  // Builds the five sensor bytes; a corrupted frame gets a wrong check byte.
  function automatic logic [39:0] sensor_frame(input logic [15:0] hum, input logic neg,
                                              input logic [14:0] mag, input logic corrupt);
    logic [7:0] b2;
    logic [7:0] sum;
    b2  = {neg, mag[14:8]};
    sum = hum[15:8] + hum[7:0] + b2 + mag[7:0];
    if (corrupt) begin
      sum = sum ^ 8'($urandom_range(255, 1));
    end
    return {hum, b2, mag[7:0], sum};
  endfunction

  function automatic logic [39:0] random_frame(input logic corrupt);
    return sensor_frame(16'($urandom_range(65535)), 1'($urandom_range(1)),
                        15'($urandom_range(32767)), corrupt);
  endfunction

  // Queues one reading as the sensor would answer it under the current
  // settings. Phase 0 is the preamble low, phase 1 the preamble high, then
  // low and high pairs per bit. The reading can be cut short by a new start
  // request, stretched into a timeout, or paused until all readouts are in.
  task automatic queue_reading(input logic [39:0] frame, input int abort_at,
                               input int stall_at, input int hold_at);
    int unsigned cap;
    int unsigned thr;
    int unsigned len;
    logic        lvl;
    cap = (line_cfg.timeout > 1) ? line_cfg.timeout - 1 : 1;
    thr = line_cfg.one_thr;
    queue_tick(FUNC_START, $urandom_range(1));
    if (line_cfg.start_low > 1) begin
      queue_noise(line_cfg.start_low - 1);
    end
    queue_noise((line_cfg.release_len == 0) ? 1 : line_cfg.release_len);
    for (int p = 0; p < DATA_PHASES; p++) begin
      lvl = ((p % 2) == 1);
      if (p == abort_at) begin
        return;
      end
      if (p == hold_at) begin
        wait_drained();
      end
      if (p == stall_at) begin
        queue_level(lvl, (line_cfg.timeout == 0) ? 1 : line_cfg.timeout);
        return;
      end
      if (p == 0) begin
        len = $urandom_range((cap < 2) ? cap : 2, 0);
      end else if (!lvl || p == 1) begin
        len = $urandom_range((cap < 2) ? cap : 2, 1);
      end else if (frame[39 - (p - 3) / 2]) begin
        len = thr + 1 + $urandom_range(1);
      end else begin
        len = (thr == 0) ? 1 : $urandom_range(thr, (thr > 1) ? thr - 1 : 1);
      end
      queue_level(lvl, len);
    end
    // The falling edge after the last high phase completes the frame.
    queue_tick(FUNC_TICK, 1'b0);
  endtask

  // One random reading: mostly well formed, some broken, some noise.
  task automatic queue_random_reading();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      queue_reading(random_frame(kind >= 60), -1, -1,
                    ($urandom_range(99) < 5) ? $urandom_range(DATA_PHASES - 1) : -1);
    end else if (kind < 80) begin
      queue_reading(random_frame(1'b0), -1, $urandom_range(DATA_PHASES - 1), -1);
    end else begin
      if (kind < 90) begin
        queue_reading(random_frame(1'b0), $urandom_range(DATA_PHASES - 1), -1, -1);
      end else begin
        repeat ($urandom_range(30, 10)) begin
          queue_tick(($urandom_range(99) < 10) ? FUNC_START : FUNC_TICK, $urandom_range(1));
        end
      end
      // A full reading afterwards returns the sequencer to idle.
      queue_reading(random_frame(1'b0), -1, -1, -1);
    end
    queue_noise($urandom_range(3));
  endtask

  // Random readings under random short timings until the tick budget is used.
  task automatic run_random_readings(input int unsigned budget);
    int unsigned first_tick;
    int unsigned thr;
    int unsigned tmo;
    first_tick = ticks_queued;
    while (ticks_queued - first_tick < budget) begin
      thr = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
      tmo = ($urandom_range(9) == 0) ? $urandom_range(2) : thr + $urandom_range(8, 3);
      apply_timing(($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(5, 1)),
                   8'($urandom_range(3, 1)), 10'(thr), 16'(tmo));
      queue_random_reading();
    end
  endtask

  // Main sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ticks while idle, then part of a start pulse under the reset timing.
    queue_noise(4);
    queue_tick(FUNC_START, 1'b1);
    queue_noise(30);

    // Directed readings under a short timing.
    apply_timing(16'd3, 8'd2, 10'd2, 16'd8);
    queue_noise(3);
    queue_reading(sensor_frame(16'd652, 1'b0, 15'd351, 1'b0), -1, -1, -1);
    queue_reading(sensor_frame(16'd420, 1'b1, 15'd101, 1'b0), -1, -1, -1);
    queue_reading(sensor_frame(16'd500, 1'b1, 15'd0, 1'b0), -1, -1, -1);
    queue_reading(sensor_frame(16'hFFFF, 1'b1, 15'h7FFF, 1'b0), -1, -1, -1);
    queue_reading(sensor_frame(16'h0000, 1'b0, 15'h0000, 1'b0), -1, -1, -1);
    queue_reading(sensor_frame(16'd333, 1'b0, 15'd222, 1'b1), -1, -1, -1);
    // Restart while busy: during the start pulse and during the data bits.
    queue_tick(FUNC_START, 1'b0);
    queue_noise(1);
    queue_reading(sensor_frame(16'd611, 1'b0, 15'd245, 1'b0), 30, -1, -1);
    queue_reading(sensor_frame(16'd612, 1'b1, 15'd55, 1'b0), -1, -1, 40);
    // Timeouts in each line phase and on the very last bit.
    queue_reading(random_frame(1'b0), -1, 0, -1);
    queue_reading(random_frame(1'b0), -1, 1, -1);
    queue_reading(random_frame(1'b0), -1, 2, -1);
    queue_reading(random_frame(1'b0), -1, 3, -1);
    queue_reading(sensor_frame(16'hFFFF, 1'b0, 15'h7FFF, 1'b0), -1, DATA_PHASES - 1, -1);

    // Zero lengths act like one; the shortest timeout ends in the preamble.
    apply_timing(16'd0, 8'd0, 10'd1, 16'd0);
    queue_reading(random_frame(1'b0), 2, -1, -1);
    apply_timing(16'd0, 8'd0, 10'd1, 16'd6);
    queue_reading(random_frame(1'b0), -1, -1, -1);
    // Lowest legal settings: every high phase decodes as one.
    apply_timing(16'd1, 8'd1, 10'd0, 16'd1);
    queue_reading(random_frame(1'b0), 2, -1, -1);
    apply_timing(16'd1, 8'd1, 10'd0, 16'd5);
    queue_reading(random_frame(1'b0), -1, -1, -1);

    run_random_readings(RANDOM_TICKS / 3);

    wait_drained();
    send_idle_pct = 80;
    recv_idle_pct = 17;
    run_random_readings(RANDOM_TICKS / 3);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_readings(RANDOM_TICKS / 3);

    // Highest settings hold the start pulse far from its end.
    apply_timing(16'hFFFF, 8'hFF, 10'h3FF, 16'hFFFF);
    queue_tick(FUNC_START, 1'b0);
    queue_noise(40);
    // Longest release, a one and a zero right at the threshold, then a low
    // phase held until the timeout.
    apply_timing(16'd1, 8'hFF, 10'd40, 16'd60);
    queue_reading(40'h80_0000_0000, -1, 6, -1);

    wait_drained();
    $display("Ran %0d ticks and %0d register writes; checked %0d readouts.",
             ticks_taken, regs_written, readouts_seen);
    $display("Readings: %0d good, %0d timed out, %0d bad checksum; %0d mismatches.",
             reads_good, reads_timeout, reads_badsum, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d readouts outstanding", expected_readouts.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
